@@ rtl/lkv_pkg.sv @@
// Package for the LRU key/value cache: sizes, op codes and transaction types.
// No dependencies; used by every module of the block but lkv_ram.
package lkv_pkg;

   localparam int CAPACITY = 64;
   localparam int KEY_BITS = 64;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int LIMIT_W  = 7;
   localparam int VALUE_W  = 16;

   // Operation codes carried in the op field
   localparam logic [1:0] OP_GET   = 2'd0;
   localparam logic [1:0] OP_PUT   = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   typedef struct packed {
      logic [1:0]         op;
      logic [63:0]        key_tag;
      logic [VALUE_W-1:0] put_value;
   } req_type;

   typedef struct packed {
      logic               hit;
      logic [VALUE_W-1:0] found_value;
      logic               evicted;
   } rsp_type;

   // Classified command handed from the front end to the executor
   typedef struct packed {
      logic               is_get;
      logic               is_put;
      logic               is_clear;
      logic [63:0]        key_tag;
      logic [VALUE_W-1:0] put_value;
   } cmd_type;

   // Occupancy status exported by the executor
   typedef struct packed {
      logic [CNT_W-1:0]    entry_count;
      logic [CAPACITY-1:0] entry_valid;
   } status_type;

endpackage

@@ rtl/lkv_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lkv_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/lkv_front.sv @@
// Front end: accepts request transactions into a two-entry queue and classifies the op.
// Depends on lkv_pkg.
module lkv_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  lkv_pkg::req_type req_payload,
   output logic            cmd_valid,
   input  logic            cmd_pop,
   output lkv_pkg::cmd_type cmd
);

   lkv_pkg::cmd_type slot_ff [2];
   lkv_pkg::cmd_type slot_in [2];
   logic             rd_ptr_ff, rd_ptr_in;
   logic             wr_ptr_ff, wr_ptr_in;
   logic [1:0]       fill_ff, fill_in;
   logic             push;
   lkv_pkg::cmd_type decoded;

   // classify the incoming op
   always_comb begin
      decoded.is_get    = (req_payload.op == lkv_pkg::OP_GET);
      decoded.is_put    = (req_payload.op == lkv_pkg::OP_PUT);
      decoded.is_clear  = (req_payload.op == lkv_pkg::OP_CLEAR);
      decoded.key_tag   = req_payload.key_tag;
      decoded.put_value = req_payload.put_value;
   end

   assign req_stall = (fill_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign cmd_valid = (fill_ff != 2'd0);
   assign cmd       = slot_ff[rd_ptr_ff];

   // queue pointers and count
   always_comb begin
      slot_in    = slot_ff;
      wr_ptr_in  = wr_ptr_ff;
      rd_ptr_in  = rd_ptr_ff;
      fill_in    = fill_ff;
      if (push) begin
         slot_in[wr_ptr_ff] = decoded;
         wr_ptr_in = !wr_ptr_ff;
      end
      if (cmd_pop && cmd_valid) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      fill_in = fill_ff + {1'b0, push} - {1'b0, cmd_pop && cmd_valid};
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

@@ rtl/lkv_back.sv @@
// Executor: tag CAM, per-slot ages, value RAM and the result register.
// Depends on lkv_pkg and lkv_ram.
module lkv_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [lkv_pkg::LIMIT_W-1:0] max_entries,
   input  logic                        cmd_valid,
   output logic                        cmd_pop,
   input  lkv_pkg::cmd_type            cmd,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output lkv_pkg::rsp_type            rsp_payload,
   output lkv_pkg::status_type         status
);

   typedef enum logic [1:0] {ST_IDLE, ST_LOOK, ST_EXEC} state_type;

   state_type                           state_ff, state_in;
   logic [lkv_pkg::CAPACITY-1:0]        valid_ff, valid_in;
   logic [lkv_pkg::KEY_BITS-1:0]        key_ff [lkv_pkg::CAPACITY];
   logic [lkv_pkg::KEY_BITS-1:0]        key_in [lkv_pkg::CAPACITY];
   logic [lkv_pkg::IDX_W-1:0]           age_ff [lkv_pkg::CAPACITY];
   logic [lkv_pkg::IDX_W-1:0]           age_in [lkv_pkg::CAPACITY];
   logic [lkv_pkg::CNT_W-1:0]           count_ff, count_in;
   lkv_pkg::cmd_type                    cur_ff, cur_in;
   logic                                hit_ff, hit_in;
   logic [lkv_pkg::IDX_W-1:0]           hit_idx_ff, hit_idx_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   lkv_pkg::rsp_type                    rsp_ff, rsp_in;

   logic [lkv_pkg::LIMIT_W-1:0]         limit;
   logic [lkv_pkg::CAPACITY-1:0]        match_vec, victim_vec, kept_vec;
   logic                                any_match;
   logic [lkv_pkg::IDX_W-1:0]           match_idx, free_idx;
   logic [lkv_pkg::IDX_W-1:0]           old_age;
   logic [lkv_pkg::CNT_W-1:0]           oldest_age;
   logic                                put_on, do_evict, rsp_free;
   logic                                ram_we;
   logic [lkv_pkg::IDX_W-1:0]           ram_waddr;
   logic [lkv_pkg::VALUE_W-1:0]         ram_rdata;

   // effective limit, clipped to capacity
   always_comb begin
      if (max_entries > lkv_pkg::LIMIT_W'(lkv_pkg::CAPACITY)) begin
         limit = lkv_pkg::LIMIT_W'(lkv_pkg::CAPACITY);
      end else begin
         limit = max_entries;
      end
   end

   // CAM match, victim search and first free slot
   always_comb begin
      oldest_age = count_ff - lkv_pkg::CNT_W'(1);
      match_idx  = '0;
      free_idx   = '0;
      for (int i = 0; i < lkv_pkg::CAPACITY; i++) begin
         match_vec[i]  = valid_ff[i] && (key_ff[i] == cur_ff.key_tag[lkv_pkg::KEY_BITS-1:0]);
         victim_vec[i] = valid_ff[i] &&
                         ({{(lkv_pkg::CNT_W-lkv_pkg::IDX_W){1'b0}}, age_ff[i]} == oldest_age);
      end
      for (int i = lkv_pkg::CAPACITY - 1; i >= 0; i--) begin
         if (match_vec[i]) begin
            match_idx = lkv_pkg::IDX_W'(i);
         end
      end
      any_match = |match_vec;
      put_on    = cur_ff.is_put && (limit != '0);
      do_evict  = put_on && !hit_ff && (count_ff != '0) &&
                  (lkv_pkg::CNT_W'(limit) <= count_ff);
      kept_vec  = do_evict ? (valid_ff & ~victim_vec) : valid_ff;
      for (int i = lkv_pkg::CAPACITY - 1; i >= 0; i--) begin
         if (!kept_vec[i]) begin
            free_idx = lkv_pkg::IDX_W'(i);
         end
      end
      old_age = age_ff[hit_idx_ff];
   end

   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   // sequencer and state updates
   always_comb begin
      state_in     = state_ff;
      valid_in     = valid_ff;
      key_in       = key_ff;
      age_in       = age_ff;
      count_in     = count_ff;
      cur_in       = cur_ff;
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      cmd_pop      = 1'b0;
      ram_we       = 1'b0;
      ram_waddr    = hit_idx_ff;
      case (state_ff)
         ST_IDLE: begin
            // trim surplus entries after a lowered limit, one per cycle
            if (count_ff > lkv_pkg::CNT_W'(limit)) begin
               valid_in = valid_ff & ~victim_vec;
               count_in = count_ff - lkv_pkg::CNT_W'(1);
            end else if (cmd_valid) begin
               cmd_pop  = 1'b1;
               cur_in   = cmd;
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            hit_in     = any_match;
            hit_idx_in = match_idx;
            state_in   = ST_EXEC;
         end
         ST_EXEC: begin
            if (rsp_free) begin
               rsp_valid_in        = 1'b1;
               rsp_in.hit          = 1'b0;
               rsp_in.found_value  = '0;
               rsp_in.evicted      = 1'b0;
               state_in            = ST_IDLE;
               if (cur_ff.is_clear) begin
                  valid_in = '0;
                  count_in = '0;
               end else if ((cur_ff.is_get || put_on) && hit_ff) begin
                  // touch: younger entries age by one
                  rsp_in.hit = 1'b1;
                  if (cur_ff.is_get) begin
                     rsp_in.found_value = ram_rdata;
                  end else begin
                     ram_we = 1'b1;
                  end
                  for (int i = 0; i < lkv_pkg::CAPACITY; i++) begin
                     if (valid_ff[i] && (age_ff[i] < old_age)) begin
                        age_in[i] = age_ff[i] + lkv_pkg::IDX_W'(1);
                     end
                  end
                  age_in[hit_idx_ff] = '0;
               end else if (put_on) begin
                  // insert as most recent, after evicting the oldest if full
                  rsp_in.evicted = do_evict;
                  for (int i = 0; i < lkv_pkg::CAPACITY; i++) begin
                     if (kept_vec[i]) begin
                        age_in[i] = age_ff[i] + lkv_pkg::IDX_W'(1);
                     end
                  end
                  valid_in           = kept_vec;
                  valid_in[free_idx] = 1'b1;
                  key_in[free_idx]   = cur_ff.key_tag[lkv_pkg::KEY_BITS-1:0];
                  age_in[free_idx]   = '0;
                  ram_we             = 1'b1;
                  ram_waddr          = free_idx;
                  if (!do_evict) begin
                     count_in = count_ff + lkv_pkg::CNT_W'(1);
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      key_ff     <= key_in;
      age_ff     <= age_in;
      cur_ff     <= cur_in;
      hit_ff     <= hit_in;
      hit_idx_ff <= hit_idx_in;
      rsp_ff     <= rsp_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   lkv_ram #(
      .WIDTH (lkv_pkg::VALUE_W),
      .DEPTH (lkv_pkg::CAPACITY)
   ) u_value_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (cur_ff.put_value),
      .rd_addr (match_idx),
      .rd_data (ram_rdata)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_payload        = rsp_ff;
   assign status.entry_count = count_ff;
   assign status.entry_valid = valid_ff;

endmodule

@@ rtl/lru_key_value_cache.sv @@
// Top level of the LRU key/value cache: limit register, front end and executor.
// Depends on lkv_pkg, lkv_front, lkv_back (and lkv_ram below it).

// Fully associative 64-entry LRU map from a 64-bit tag to a 16-bit value. A
// transaction passes through the executor states issue, CAM match with value
// read, and update and result; the executor handles one at a time because each
// update of the recency ages is read by the next lookup. A two-entry queue in
// front lets requests be taken while a result waits in the output register.
// Lowering the limit written through csr_write_data trims surplus entries one
// per cycle before the next request is executed. Values above 64 act as 64;
// zero makes puts do nothing.
module lru_key_value_cache (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  lkv_pkg::req_type            req_payload,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output lkv_pkg::rsp_type            rsp_payload,
   input  logic                        csr_write_enable,
   input  logic [lkv_pkg::LIMIT_W-1:0] csr_write_data
);

   logic [lkv_pkg::LIMIT_W-1:0] max_entries_ff, max_entries_in;
   logic                        cmd_valid;
   logic                        cmd_pop;
   lkv_pkg::cmd_type            cmd;
   lkv_pkg::status_type         status;

   // limit register
   assign max_entries_in = csr_write_enable ? csr_write_data : max_entries_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_entries_ff <= lkv_pkg::LIMIT_W'(lkv_pkg::CAPACITY);
      end else begin
         max_entries_ff <= max_entries_in;
      end
   end

   lkv_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .cmd_valid   (cmd_valid),
      .cmd_pop     (cmd_pop),
      .cmd         (cmd)
   );

   lkv_back u_back (
      .clock       (clock),
      .reset       (reset),
      .max_entries (max_entries_ff),
      .cmd_valid   (cmd_valid),
      .cmd_pop     (cmd_pop),
      .cmd         (cmd),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .status      (status)
   );

   // occupancy count tracks the valid bits
   assert property (@(posedge clock) disable iff (reset)
      $countones(status.entry_valid) == int'(status.entry_count))
      else $error("entry count out of step with valid bits");

   // never more entries than slots
   assert property (@(posedge clock) disable iff (reset)
      status.entry_count <= lkv_pkg::CNT_W'(lkv_pkg::CAPACITY))
      else $error("entry count above capacity");

   // an eviction only happens on a miss
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_payload.hit && rsp_payload.evicted))
      else $error("eviction reported on a hit");

   // a returned value implies a hit
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_payload.found_value != '0)) |-> rsp_payload.hit)
      else $error("value returned without a hit");

endmodule

@@ verif/lkv_checker.sv @@
// Checker for the LRU key/value cache: predicts each response from accepted requests.
// Depends on lkv_pkg; instantiated beside the cache by tb_lru_key_value_cache.
`timescale 1ns / 1ps

module lkv_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_stall,
   input  lkv_pkg::req_type            req_payload,
   input  logic                        rsp_valid,
   input  logic                        rsp_stall,
   input  lkv_pkg::rsp_type            rsp_payload,
   input  logic                        csr_write_enable,
   input  logic [lkv_pkg::LIMIT_W-1:0] csr_write_data,
   output int                          fail_count,
   output int                          pending_count,
   output int                          rsp_seen,
   output int                          hit_seen,
   output int                          evict_seen
);

   logic                        slot_used [lkv_pkg::CAPACITY];
   logic [63:0]                 slot_key  [lkv_pkg::CAPACITY];
   logic [lkv_pkg::VALUE_W-1:0] slot_val  [lkv_pkg::CAPACITY];
   int                          slot_age  [lkv_pkg::CAPACITY];
   int                          used_count;
   int                          limit_reg;
   lkv_pkg::rsp_type            expected_q[$];

   function automatic int eff_limit();
      return (limit_reg > lkv_pkg::CAPACITY) ? lkv_pkg::CAPACITY : limit_reg;
   endfunction

   function automatic int lookup(logic [63:0] key);
      for (int i = 0; i < lkv_pkg::CAPACITY; i++)
         if (slot_used[i] && slot_key[i] == key) return i;
      return -1;
   endfunction

   // Promote slot s to most recent
   function automatic void promote(int s);
      int old_age;
      old_age = slot_age[s];
      for (int i = 0; i < lkv_pkg::CAPACITY; i++)
         if (slot_used[i] && slot_age[i] < old_age) slot_age[i]++;
      slot_age[s] = 0;
   endfunction

   function automatic void drop_oldest();
      if (used_count == 0) return;
      for (int i = 0; i < lkv_pkg::CAPACITY; i++)
         if (slot_used[i] && slot_age[i] == used_count - 1) begin
            slot_used[i] = 1'b0;
            used_count--;
            return;
         end
   endfunction

   function automatic void add_entry(logic [63:0] key, logic [lkv_pkg::VALUE_W-1:0] v);
      int slot;
      slot = -1;
      for (int i = 0; i < lkv_pkg::CAPACITY; i++)
         if (slot_used[i]) slot_age[i]++;
         else if (slot < 0) slot = i;
      if (slot < 0) return;
      slot_used[slot] = 1'b1;
      slot_key[slot]  = key;
      slot_val[slot]  = v;
      slot_age[slot]  = 0;
      used_count++;
   endfunction

   function automatic lkv_pkg::rsp_type apply_request(lkv_pkg::req_type r);
      lkv_pkg::rsp_type res;
      int s;
      res = '0;
      case (r.op)
         lkv_pkg::OP_GET: begin
            s = lookup(r.key_tag);
            if (s >= 0) begin
               res.hit = 1'b1;
               res.found_value = slot_val[s];
               promote(s);
            end
         end
         lkv_pkg::OP_PUT: begin
            if (eff_limit() != 0) begin
               s = lookup(r.key_tag);
               if (s >= 0) begin
                  res.hit = 1'b1;
                  slot_val[s] = r.put_value;
                  promote(s);
               end else begin
                  if (used_count >= eff_limit() && used_count > 0) begin
                     drop_oldest();
                     res.evicted = 1'b1;
                  end
                  add_entry(r.key_tag, r.put_value);
               end
            end
         end
         lkv_pkg::OP_CLEAR: begin
            for (int i = 0; i < lkv_pkg::CAPACITY; i++) slot_used[i] = 1'b0;
            used_count = 0;
         end
         default: ;
      endcase
      return res;
   endfunction

   // Track limit writes, accepted requests and responses at each rising edge
   always @(posedge clock) begin
      lkv_pkg::rsp_type want;
      if (reset) begin
         for (int i = 0; i < lkv_pkg::CAPACITY; i++) slot_used[i] = 1'b0;
         used_count = 0;
         limit_reg  = lkv_pkg::CAPACITY;
         expected_q.delete();
         fail_count = 0;
         rsp_seen   = 0;
         hit_seen   = 0;
         evict_seen = 0;
      end else begin
         if (csr_write_enable) begin
            limit_reg = int'(csr_write_data);
            while (used_count > eff_limit()) drop_oldest();
         end
         if (req_valid && !req_stall) expected_q.push_back(apply_request(req_payload));
         if (rsp_valid && !rsp_stall) begin
            rsp_seen++;
            if (rsp_payload.hit) hit_seen++;
            if (rsp_payload.evicted) evict_seen++;
            if (expected_q.size() == 0) begin
               $display("%0t: response with nothing expected, actual %p", $time, rsp_payload);
               fail_count++;
            end else begin
               want = expected_q.pop_front();
               if (want.hit !== rsp_payload.hit)
                  $display("%0t: hit expected %0b actual %0b", $time, want.hit, rsp_payload.hit);
               if (want.found_value !== rsp_payload.found_value)
                  $display("%0t: found_value expected %h actual %h", $time,
                           want.found_value, rsp_payload.found_value);
               if (want.evicted !== rsp_payload.evicted)
                  $display("%0t: evicted expected %0b actual %0b", $time,
                           want.evicted, rsp_payload.evicted);
               if (want !== rsp_payload) fail_count++;
            end
         end
      end
      pending_count = expected_q.size();
   end

endmodule

@@ verif/tb_lru_key_value_cache.sv @@
// Testbench top for the LRU key/value cache: clock, reset, stimulus and verdict.
// Depends on lkv_pkg, lru_key_value_cache and lkv_checker.
`timescale 1ns / 1ps

module tb_lru_key_value_cache;

   // op code with no operation behind it
   localparam logic [1:0] OP_SPARE = 2'd3;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   lkv_pkg::req_type            req_payload = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   lkv_pkg::rsp_type            rsp_payload;
   logic                        csr_write_enable = 1'b0;
   logic [lkv_pkg::LIMIT_W-1:0] csr_write_data = '0;
   int                          fail_count, pending_count, rsp_seen, hit_seen, evict_seen;
   int                          idle_pct = 7;
   int                          req_sent = 0;
   logic [63:0]                 key_pool [16];

   always #5 clock = ~clock;

   lru_key_value_cache dut (.*);

   lkv_checker u_checker (.*);

   // Random back-pressure on the response side
   always @(negedge clock)
      rsp_stall <= !reset && ($urandom_range(99) < idle_pct);

   // Present one request and hold it until accepted; random gaps before it
   task automatic send_request(logic [1:0] op, logic [63:0] key, logic [15:0] v);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= '{op: op, key_tag: key, put_value: v};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      req_sent++;
   endtask

   // Drain, write the limit, then let trimming settle
   task automatic set_limit(int lim);
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= lkv_pkg::LIMIT_W'(lim);
      @(negedge clock);
      csr_write_enable <= 1'b0;
      repeat (80) @(negedge clock);
   endtask

   function automatic logic [63:0] pick_key();
      return ($urandom_range(9) < 8) ? key_pool[$urandom_range(15)]
                                     : {$urandom, $urandom};
   endfunction

   // Random phase mixed towards gets and puts on a small key set
   task automatic random_phase(int n);
      int r;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(99);
         if (r < 45)      send_request(lkv_pkg::OP_GET, pick_key(), 16'($urandom));
         else if (r < 94) send_request(lkv_pkg::OP_PUT, pick_key(), 16'($urandom));
         else if (r < 97) send_request(lkv_pkg::OP_CLEAR, {$urandom, $urandom},
                                       16'($urandom));
         else             send_request(OP_SPARE, pick_key(), 16'($urandom));
      end
   endtask

   initial begin
      for (int i = 0; i < 16; i++) key_pool[i] = {$urandom, $urandom};
      key_pool[0] = '0;
      key_pool[1] = '1;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: extremes, every op, hits, updates, clear and unused op
      send_request(lkv_pkg::OP_GET, '0, '0);
      send_request(lkv_pkg::OP_PUT, '0, 16'hffff);
      send_request(lkv_pkg::OP_PUT, '1, 16'h0000);
      send_request(lkv_pkg::OP_GET, '0, 16'h1234);
      send_request(lkv_pkg::OP_GET, '1, '0);
      send_request(lkv_pkg::OP_PUT, '0, 16'h5a5a);
      send_request(lkv_pkg::OP_GET, '0, '0);
      send_request(OP_SPARE, '0, 16'hffff);
      send_request(lkv_pkg::OP_CLEAR, '0, '0);
      send_request(lkv_pkg::OP_GET, '0, '0);
      set_limit(2);
      send_request(lkv_pkg::OP_PUT, 64'h1, 16'h1);
      send_request(lkv_pkg::OP_PUT, 64'h2, 16'h2);
      send_request(lkv_pkg::OP_GET, 64'h1, '0);
      send_request(lkv_pkg::OP_PUT, 64'h3, 16'h3);
      send_request(lkv_pkg::OP_GET, 64'h2, '0);
      set_limit(0);
      send_request(lkv_pkg::OP_PUT, 64'h1, 16'h7);
      send_request(lkv_pkg::OP_PUT, 64'h9, 16'h9);
      send_request(lkv_pkg::OP_GET, 64'h1, '0);

      // Random phases over several limits, raising and lowering the limit
      set_limit(127);
      random_phase(250);
      set_limit(64);
      idle_pct = 0;
      random_phase(200);
      idle_pct = 7;
      set_limit(5);
      random_phase(200);
      set_limit(65);
      random_phase(200);
      set_limit(3);
      random_phase(200);
      set_limit(1);
      random_phase(150);
      set_limit(0);
      random_phase(50);
      set_limit(12);
      random_phase(200);

      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      $display("covered %0d requests, %0d responses, %0d hits, %0d evictions",
               req_sent, rsp_seen, hit_seen, evict_seen);
      $display("limits 0, 1, 2, 3, 5, 12, 64, 65 and 127 with get, put, clear, unused op");
      if (fail_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   initial begin
      #5ms;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

@@ files.f @@
rtl/lkv_pkg.sv
rtl/lkv_ram.sv
rtl/lkv_front.sv
rtl/lkv_back.sv
rtl/lru_key_value_cache.sv
verif/lkv_checker.sv
verif/tb_lru_key_value_cache.sv
